// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/gww_pkg.sv
// ----------------------------------------------------------------------------
// gww_pkg
// Shared constants, types and helpers for the greedy word wrap block.
// ----------------------------------------------------------------------------
`default_nettype none

package gww_pkg;

  // Default for the largest supported line width
  localparam int MAX_COLUMNS_DEF = 63;

  // Field widths
  localparam int CHAR_W = 8;
  localparam int CFG_W  = 6;

  // Reset value of the line width register
  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 6'd63;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // Control from the sequencer to every cell of the word chain
  typedef struct packed {
    logic              push;
    logic              shift;
    logic [CHAR_W-1:0] data;
  } chain_ctl_t;

  // Whitespace: tab through carriage return, and space
  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

`default_nettype wire

// File: src/gww_cell.sv
// ----------------------------------------------------------------------------
// gww_cell
// One byte cell of the word chain: loads on a push to its own slot and takes
// its upper neighbor's byte on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_cell #(
  parameter int CW  = 6,
  parameter int IDX = 0
) (
  input  wire                             clk,
  input  gww_pkg::chain_ctl_t             ctl,
  input  wire  [CW-1:0]                   push_idx,
  input  wire  [gww_pkg::CHAR_W-1:0]      nbr_char,
  output logic [gww_pkg::CHAR_W-1:0]      cell_char
);

  logic [gww_pkg::CHAR_W-1:0] char_r;
  logic [gww_pkg::CHAR_W-1:0] char_nxt;

  // Load on a push into this slot, else move down on a shift
  always_comb begin
    char_nxt = char_r;
    if (ctl.push && (push_idx == CW'(IDX))) begin
      char_nxt = ctl.data;
    end else if (ctl.shift) begin
      char_nxt = nbr_char;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign cell_char = char_r;

endmodule

`default_nettype wire

// File: src/gww_word_chain.sv
// ----------------------------------------------------------------------------
// gww_word_chain
// Row of byte cells holding the word after the pending whitespace; the head
// cell gives the oldest byte and a shift moves every byte one place down.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_word_chain #(
  parameter int MAX_COLUMNS = gww_pkg::MAX_COLUMNS_DEF,
  parameter int CW          = $clog2(MAX_COLUMNS + 1)
) (
  input  wire                             clk,
  input  gww_pkg::chain_ctl_t             ctl,
  input  wire  [CW-1:0]                   push_idx,
  output logic [gww_pkg::CHAR_W-1:0]      head_char
);

  logic [gww_pkg::CHAR_W-1:0] cell_q [MAX_COLUMNS];

  // Build the row; the top cell shifts in zero
  for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_cell
    logic [gww_pkg::CHAR_W-1:0] nbr;
    if (i == MAX_COLUMNS - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    gww_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .push_idx  (push_idx),
      .nbr_char  (nbr),
      .cell_char (cell_q[i])
    );
  end

  assign head_char = cell_q[0];

endmodule

`default_nettype wire

// File: src/gww_ctrl.sv
// ----------------------------------------------------------------------------
// gww_ctrl
// Line-break sequencer: decides the break for each byte, keeps the line
// state and plays out the resulting bytes through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_ctrl #(
  parameter int MAX_COLUMNS = gww_pkg::MAX_COLUMNS_DEF,
  parameter int CW          = $clog2(MAX_COLUMNS + 1)
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire  [CW-1:0]                   width,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [gww_pkg::CHAR_W-1:0]      in_tdata,
  input  wire                             in_tlast,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [gww_pkg::CHAR_W-1:0]      out_tdata,
  output logic                            out_tlast,
  output gww_pkg::chain_ctl_t             chain_ctl,
  output logic [CW-1:0]                   push_idx,
  input  wire  [gww_pkg::CHAR_W-1:0]      head_char
);

  localparam int TW = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_DRAIN1,
    S_MID,
    S_DRAIN2
  } state_t;

  // Pick the first step that still has a byte to send
  function automatic state_t first_state(input logic a, input logic d1,
                                         input logic b, input logic d2);
    state_t s;
    s = S_IDLE;
    if (a) begin
      s = S_PRE;
    end else if (d1) begin
      s = S_DRAIN1;
    end else if (b) begin
      s = S_MID;
    end else if (d2) begin
      s = S_DRAIN2;
    end
    return s;
  endfunction

  state_t                     state_r,   state_nxt;
  logic [CW-1:0]              wl_r,      wl_nxt;
  logic [CW-1:0]              ll_r,      ll_nxt;
  logic [gww_pkg::CHAR_W-1:0] held_r,    held_nxt;
  logic                       hsv_r,     hsv_nxt;
  logic                       a_v_r,     a_v_nxt;
  logic [gww_pkg::CHAR_W-1:0] a_c_r,     a_c_nxt;
  logic                       d1_r,      d1_nxt;
  logic                       b_v_r,     b_v_nxt;
  logic [gww_pkg::CHAR_W-1:0] b_c_r,     b_c_nxt;
  logic                       d2_r,      d2_nxt;
  logic                       ov_r,      ov_nxt;
  logic [gww_pkg::CHAR_W-1:0] od_r,      od_nxt;
  logic                       ol_r,      ol_nxt;

  always_comb begin
    logic                       slot_free;
    logic                       emit;
    logic [gww_pkg::CHAR_W-1:0] emit_c;
    logic [TW-1:0]              total;
    logic                       full;
    logic                       ws;
    logic                       nl;
    logic                       push;
    logic                       post_v;
    logic [gww_pkg::CHAR_W-1:0] post_c;

    state_nxt = state_r;
    wl_nxt    = wl_r;
    ll_nxt    = ll_r;
    held_nxt  = held_r;
    hsv_nxt   = hsv_r;
    a_v_nxt   = a_v_r;
    a_c_nxt   = a_c_r;
    d1_nxt    = d1_r;
    b_v_nxt   = b_v_r;
    b_c_nxt   = b_c_r;
    d2_nxt    = d2_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    ol_nxt    = ol_r;

    slot_free = !ov_r || out_tready;
    emit      = 1'b0;
    emit_c    = head_char;
    push      = 1'b0;
    post_v    = 1'b0;
    post_c    = in_tdata;
    ws        = gww_pkg::is_ws(in_tdata);
    nl        = (in_tdata == gww_pkg::CHAR_NL);
    total     = TW'(ll_r) + TW'(hsv_r) + TW'(wl_r);
    full      = (total >= TW'(width));

    chain_ctl.push  = 1'b0;
    chain_ctl.shift = 1'b0;
    chain_ctl.data  = in_tdata;

    // Drop the output byte once it is taken
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          a_v_nxt = 1'b0;
          a_c_nxt = held_r;
          d1_nxt  = 1'b0;
          d2_nxt  = 1'b0;
          if (nl || (ws && full)) begin
            // Break here: held space and word go out, then a newline
            a_v_nxt = hsv_r;
            d1_nxt  = 1'b1;
            post_v  = 1'b1;
            post_c  = gww_pkg::CHAR_NL;
            ll_nxt  = '0;
            hsv_nxt = 1'b0;
          end else if (ws) begin
            // Commit held space and word to the line, hold the new space
            a_v_nxt  = hsv_r;
            d1_nxt   = 1'b1;
            ll_nxt   = ll_r + CW'(hsv_r) + wl_r;
            hsv_nxt  = 1'b1;
            held_nxt = in_tdata;
          end else if (!full) begin
            push = 1'b1;
          end else if (hsv_r) begin
            // Held space becomes the break, word moves to the next line
            a_v_nxt = 1'b1;
            a_c_nxt = gww_pkg::CHAR_NL;
            hsv_nxt = 1'b0;
            ll_nxt  = '0;
            push    = 1'b1;
          end else begin
            // Overlong word: pass it unbroken, line stays full
            d1_nxt = 1'b1;
            post_v = 1'b1;
            ll_nxt = width;
          end

          b_v_nxt = post_v;
          b_c_nxt = post_c;
          if (in_tlast) begin
            // Flush held space and word at end of text
            d2_nxt = 1'b1;
            ll_nxt = '0;
            if (!post_v && hsv_nxt) begin
              b_v_nxt = 1'b1;
              b_c_nxt = held_nxt;
            end
            hsv_nxt = 1'b0;
          end

          wl_nxt         = wl_r + CW'(push);
          chain_ctl.push = push;
          state_nxt = first_state(a_v_nxt, d1_nxt && (wl_r != '0), b_v_nxt,
                                  d2_nxt && (wl_nxt != '0));
        end
      end
      S_PRE: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_c    = a_c_r;
          state_nxt = first_state(1'b0, d1_r && (wl_r != '0), b_v_r,
                                  d2_r && (wl_r != '0));
        end
      end
      S_DRAIN1: begin
        if (slot_free) begin
          emit            = 1'b1;
          chain_ctl.shift = 1'b1;
          wl_nxt          = wl_r - CW'(1);
          state_nxt = (wl_r != CW'(1)) ? S_DRAIN1
                                       : first_state(1'b0, 1'b0, b_v_r, 1'b0);
        end
      end
      S_MID: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_c    = b_c_r;
          state_nxt = first_state(1'b0, 1'b0, 1'b0, d2_r && (wl_r != '0));
        end
      end
      S_DRAIN2: begin
        if (slot_free) begin
          emit            = 1'b1;
          chain_ctl.shift = 1'b1;
          wl_nxt          = wl_r - CW'(1);
          state_nxt       = (wl_r != CW'(1)) ? S_DRAIN2 : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Load the output register; the run ends when the sequencer goes idle
    if (emit) begin
      ov_nxt = 1'b1;
      od_nxt = emit_c;
      ol_nxt = (state_nxt == S_IDLE);
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wl_r    <= '0;
      ll_r    <= '0;
      hsv_r   <= 1'b0;
      a_v_r   <= 1'b0;
      d1_r    <= 1'b0;
      b_v_r   <= 1'b0;
      d2_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wl_r    <= wl_nxt;
      ll_r    <= ll_nxt;
      hsv_r   <= hsv_nxt;
      a_v_r   <= a_v_nxt;
      d1_r    <= d1_nxt;
      b_v_r   <= b_v_nxt;
      d2_r    <= d2_nxt;
      ov_r    <= ov_nxt;
    end
    held_r <= held_nxt;
    a_c_r  <= a_c_nxt;
    b_c_r  <= b_c_nxt;
    od_r   <= od_nxt;
    ol_r   <= ol_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign push_idx   = wl_r;

endmodule

`default_nettype wire

// File: src/greedy_word_wrap_top.sv
// ----------------------------------------------------------------------------
// greedy_word_wrap_top
// Greedy word wrap: passes text bytes through and turns one whitespace per
// line into a newline so lines keep to the configured width, bar overlong words.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  tdata            tuser / tlast
//   in_      in   in_char[7:0]     tlast = end_of_text
//   out_     out  out_char[7:0]    tlast = last_of_run
//   cfg_     in   line_width[5:0]  write enable only
//
// An item is accepted in the idle state and yields 0 to 64 result bytes,
// which the sequencer sends one byte a cycle, with the word chain's bytes, while the output is not stalled.
// The output register lets the last byte of an item wait while the next item
// is taken. A stalled output holds the sequencer in place.
// Synchronous reset clears the control state; the word chain is not cleared
// and holds no valid data until bytes are pushed into it.
//
`default_nettype none

module greedy_word_wrap_top #(
  parameter int MAX_COLUMNS = gww_pkg::MAX_COLUMNS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_wr_en,
  input  wire  [gww_pkg::CFG_W-1:0]       cfg_wr_data,   // [5:0] line_width
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [gww_pkg::CHAR_W-1:0]      in_tdata,      // [7:0] in_char
  input  wire                             in_tlast,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [gww_pkg::CHAR_W-1:0]      out_tdata,     // [7:0] out_char
  output logic                            out_tlast
);

  localparam int CW = $clog2(MAX_COLUMNS + 1);

  logic [gww_pkg::CFG_W-1:0]  line_width_r;
  logic [gww_pkg::CFG_W-1:0]  line_width_nxt;
  logic [gww_pkg::CFG_W-1:0]  width_clamped;
  logic [CW-1:0]              width;
  gww_pkg::chain_ctl_t        chain_ctl;
  logic [CW-1:0]              push_idx;
  logic [gww_pkg::CHAR_W-1:0] head_char;

  // Take a configuration write
  always_comb begin
    line_width_nxt = line_width_r;
    if (cfg_wr_en) begin
      line_width_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= gww_pkg::LINE_WIDTH_RST;
    end else begin
      line_width_r <= line_width_nxt;
    end
  end

  // Limit the width to 1..MAX_COLUMNS
  always_comb begin
    width_clamped = line_width_r;
    if (line_width_r == '0) begin
      width_clamped = gww_pkg::CFG_W'(1);
    end else if (line_width_r > gww_pkg::CFG_W'(MAX_COLUMNS)) begin
      width_clamped = gww_pkg::CFG_W'(MAX_COLUMNS);
    end
  end

  assign width = CW'(width_clamped);

  gww_ctrl #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .CW          (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .width      (width),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .chain_ctl  (chain_ctl),
    .push_idx   (push_idx),
    .head_char  (head_char)
  );

  gww_word_chain #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .CW          (CW)
  ) u_chain (
    .clk       (clk),
    .ctl       (chain_ctl),
    .push_idx  (push_idx),
    .head_char (head_char)
  );

endmodule

`default_nettype wire

// File: src/gww_checker.sv
// ----------------------------------------------------------------------------
// gww_checker
// Port-level checks on the greedy word wrap block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gww_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             cfg_wr_en,
  input wire [gww_pkg::CFG_W-1:0]        cfg_wr_data,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire [gww_pkg::CHAR_W-1:0]       in_tdata,
  input wire                             in_tlast,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [gww_pkg::CHAR_W-1:0]       out_tdata,
  input wire                             out_tlast
);

  // A stalled result transfer holds its byte and flag
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output changed while stalled")

  // A fresh result only appears while an item is being played out
  `ASSERT_CLK(a_out_rise_busy, clk, rst_n, $rose(out_tvalid) |-> !$past(in_tready), "result appeared while idle")

  // A result that is not the last of its run means the item is still busy
  `ASSERT_CLK(a_run_busy, clk, rst_n, out_tvalid && !out_tlast |-> !in_tready, "input taken mid-run")

  // Reset leaves the block idle with no result pending
  `ASSERT_CLK_NR(a_reset_idle, clk, !rst_n |=> !out_tvalid && in_tready, "not idle after reset")

endmodule

bind greedy_word_wrap_top gww_checker u_gww_checker (.*);

`default_nettype wire
